[src/kth_ancestor_binary_lifting_defines.svh]
// Assertion macros used by the checker file.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define KAB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kab_pkg.sv]
package kab_pkg;

  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned NODE_W  = 16;
  localparam int unsigned VAL_W   = 17;
  localparam int unsigned COUNT_W = 17;

  localparam logic [VAL_W-1:0]   VAL_NONE    = '1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROOT,
    ST_BRD,
    ST_BMID,
    ST_BUP,
    ST_QSTEP,
    ST_QWAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_CUR,
    ADDR_NODE,
    ADDR_RDATA
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_PARENT,
    WD_NONE,
    WD_RDATA
  } wdata_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_NONE,
    RES_CUR,
    RES_RDATA
  } res_sel_e;

  typedef enum logic [2:0] {
    LVL_HOLD,
    LVL_CLEAR,
    LVL_INC,
    LVL_DEC,
    LVL_TOP
  } lvl_op_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_ONE,
    IDX_INC
  } idx_op_e;

  typedef struct packed {
    logic       latch_req;
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_e  addr_sel;
    logic       lvl_plus;
    wdata_sel_e wdata_sel;
    lvl_op_e    lvl_op;
    idx_op_e    idx_op;
    logic       cur_node;
    logic       cur_rdata;
    logic       res_load;
    res_sel_e   res_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              count_zero;
    logic              count_le1;
    logic              query_bad;
    logic              node_in_range;
    logic              lvl_zero;
    logic              lvl_top;
    logic              lvl_next_top;
    logic              idx_last;
    logic              step_bit;
    logic              rd_is_node;
  } status_t;

endpackage

[src/kab_if.sv]
interface kab_req_if;
  logic                              valid;
  logic                              ready;
  logic        [kab_pkg::TYPE_W-1:0] req_type;
  logic        [kab_pkg::NODE_W-1:0] node;
  logic signed [kab_pkg::VAL_W-1:0]  parent;
  logic        [kab_pkg::VAL_W-1:0]  steps;

  modport source (output valid, req_type, node, parent, steps, input ready);
  modport sink (input valid, req_type, node, parent, steps, output ready);
endinterface

interface kab_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [kab_pkg::VAL_W-1:0] ancestor;
  logic                             is_query;

  modport source (output valid, ancestor, is_query, input ready);
  modport sink (input valid, ancestor, is_query, output ready);
endinterface

interface kab_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [kab_pkg::COUNT_W-1:0]  node_count;

  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

[src/kab_ctrl.sv]
module kab_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic             rsp_ready_i,
  output logic             rsp_valid_o,
  input  kab_pkg::status_t status_i,
  output kab_pkg::cmd_t    cmd_o
);

  kab_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kab_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      kab_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          cmd_o.lvl_op    = kab_pkg::LVL_CLEAR;
          state_d         = kab_pkg::ST_DISPATCH;
        end
      end
      kab_pkg::ST_DISPATCH: begin
        case (status_i.req_type)
          kab_pkg::REQ_LOAD: begin
            cmd_o.addr_sel  = kab_pkg::ADDR_NODE;
            cmd_o.wdata_sel = kab_pkg::WD_PARENT;
            cmd_o.lvl_op    = kab_pkg::LVL_CLEAR;
            cmd_o.mem_wr    = status_i.node_in_range;
            cmd_o.res_load  = 1'b1;
            cmd_o.res_sel   = kab_pkg::RES_ZERO;
            state_d         = kab_pkg::ST_DONE;
          end
          kab_pkg::REQ_BUILD: begin
            if (status_i.count_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = kab_pkg::RES_ZERO;
              state_d        = kab_pkg::ST_DONE;
            end else begin
              cmd_o.lvl_op = kab_pkg::LVL_CLEAR;
              cmd_o.idx_op = kab_pkg::IDX_CLEAR;
              state_d      = kab_pkg::ST_ROOT;
            end
          end
          kab_pkg::REQ_QUERY: begin
            if (status_i.query_bad) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = kab_pkg::RES_NONE;
              state_d        = kab_pkg::ST_DONE;
            end else begin
              cmd_o.cur_node = 1'b1;
              cmd_o.lvl_op   = kab_pkg::LVL_TOP;
              state_d        = kab_pkg::ST_QSTEP;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = kab_pkg::RES_ZERO;
            state_d        = kab_pkg::ST_DONE;
          end
        endcase
      end
      kab_pkg::ST_ROOT: begin
        cmd_o.mem_wr    = 1'b1;
        cmd_o.addr_sel  = kab_pkg::ADDR_IDX;
        cmd_o.wdata_sel = kab_pkg::WD_NONE;
        if (status_i.lvl_top) begin
          cmd_o.lvl_op = kab_pkg::LVL_CLEAR;
          cmd_o.idx_op = kab_pkg::IDX_ONE;
          if (status_i.count_le1) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = kab_pkg::RES_ZERO;
            state_d        = kab_pkg::ST_DONE;
          end else begin
            state_d = kab_pkg::ST_BRD;
          end
        end else begin
          cmd_o.lvl_op = kab_pkg::LVL_INC;
        end
      end
      kab_pkg::ST_BRD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = kab_pkg::ADDR_IDX;
        state_d        = kab_pkg::ST_BMID;
      end
      kab_pkg::ST_BMID, kab_pkg::ST_BUP: begin
        if (state_q == kab_pkg::ST_BMID && status_i.rd_is_node) begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = kab_pkg::ADDR_RDATA;
          state_d        = kab_pkg::ST_BUP;
        end else begin
          cmd_o.mem_wr    = 1'b1;
          cmd_o.addr_sel  = kab_pkg::ADDR_IDX;
          cmd_o.lvl_plus  = 1'b1;
          cmd_o.wdata_sel = (state_q == kab_pkg::ST_BUP) ? kab_pkg::WD_RDATA
                                                         : kab_pkg::WD_NONE;
          state_d         = kab_pkg::ST_BRD;
          if (!status_i.idx_last) begin
            cmd_o.idx_op = kab_pkg::IDX_INC;
          end else if (status_i.lvl_next_top) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = kab_pkg::RES_ZERO;
            state_d        = kab_pkg::ST_DONE;
          end else begin
            cmd_o.lvl_op = kab_pkg::LVL_INC;
            cmd_o.idx_op = kab_pkg::IDX_ONE;
          end
        end
      end
      kab_pkg::ST_QSTEP: begin
        if (status_i.step_bit) begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = kab_pkg::ADDR_CUR;
          state_d        = kab_pkg::ST_QWAIT;
        end else if (status_i.lvl_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = kab_pkg::RES_CUR;
          state_d        = kab_pkg::ST_DONE;
        end else begin
          cmd_o.lvl_op = kab_pkg::LVL_DEC;
        end
      end
      kab_pkg::ST_QWAIT: begin
        if (!status_i.rd_is_node) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = kab_pkg::RES_NONE;
          state_d        = kab_pkg::ST_DONE;
        end else if (status_i.lvl_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = kab_pkg::RES_RDATA;
          state_d        = kab_pkg::ST_DONE;
        end else begin
          cmd_o.cur_rdata = 1'b1;
          cmd_o.lvl_op    = kab_pkg::LVL_DEC;
          state_d         = kab_pkg::ST_QSTEP;
        end
      end
      kab_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = kab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kab_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign req_ready_o = (state_q == kab_pkg::ST_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

[src/kab_dp.sv]
module kab_dp #(
  parameter int unsigned MAX_NODES   = 65536,
  parameter int unsigned LIFT_LEVELS = 17
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic        [kab_pkg::TYPE_W-1:0]   req_type_i,
  input  logic        [kab_pkg::NODE_W-1:0]   node_i,
  input  logic signed [kab_pkg::VAL_W-1:0]    parent_i,
  input  logic        [kab_pkg::VAL_W-1:0]    steps_i,
  input  logic                                cfg_we_i,
  input  logic        [kab_pkg::COUNT_W-1:0]  cfg_count_i,
  input  kab_pkg::cmd_t                       cmd_i,
  output kab_pkg::status_t                    status_o,
  output logic signed [kab_pkg::VAL_W-1:0]    ancestor_o,
  output logic                                is_query_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned LW    = $clog2(LIFT_LEVELS);
  localparam int unsigned CW    = (NW + 1 > kab_pkg::COUNT_W) ? NW + 1 : kab_pkg::COUNT_W;
  localparam int unsigned DEPTH = LIFT_LEVELS * MAX_NODES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = kab_pkg::VAL_W;

  logic [kab_pkg::TYPE_W-1:0]  req_type_q;
  logic [kab_pkg::NODE_W-1:0]  node_q;
  logic [VW-1:0]               parent_q;
  logic [VW-1:0]               steps_q;
  logic [kab_pkg::COUNT_W-1:0] count_q;
  logic [LW-1:0]               lvl_q, lvl_d;
  logic [NW-1:0]               idx_q, idx_d;
  logic [VW-1:0]               cur_q;
  logic [VW-1:0]               res_q;
  logic                        res_isq_q;
  logic [VW-1:0]               anc_q;
  logic                        isq_q;
  logic [VW-1:0]               rdata_q;
  logic [VW-1:0]               mem [DEPTH];

  logic [CW-1:0] count_ext;
  logic [CW-1:0] max_ext;
  logic [CW-1:0] cnt;
  logic [LW-1:0] lvl_sel;
  logic [NW-1:0] node_sel;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata;
  logic [VW-1:0] parent_val;
  logic [VW-1:0] steps_shift;
  logic [VW-1:0] res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= kab_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_count_i;
    end
  end

  assign count_ext = CW'(count_q);
  assign max_ext   = CW'(MAX_NODES);
  assign cnt       = (count_ext > max_ext) ? max_ext : count_ext;

  always_comb begin
    case (cmd_i.lvl_op)
      kab_pkg::LVL_CLEAR: lvl_d = '0;
      kab_pkg::LVL_INC:   lvl_d = lvl_q + 1'b1;
      kab_pkg::LVL_DEC:   lvl_d = lvl_q - 1'b1;
      kab_pkg::LVL_TOP:   lvl_d = LW'(LIFT_LEVELS - 1);
      default:            lvl_d = lvl_q;
    endcase
    case (cmd_i.idx_op)
      kab_pkg::IDX_CLEAR: idx_d = '0;
      kab_pkg::IDX_ONE:   idx_d = NW'(1);
      kab_pkg::IDX_INC:   idx_d = idx_q + 1'b1;
      default:            idx_d = idx_q;
    endcase
    case (cmd_i.res_sel)
      kab_pkg::RES_NONE:  res_d = kab_pkg::VAL_NONE;
      kab_pkg::RES_CUR:   res_d = cur_q;
      kab_pkg::RES_RDATA: res_d = rdata_q;
      default:            res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q <= req_type_i;
      node_q     <= node_i;
      parent_q   <= parent_i;
      steps_q    <= steps_i;
    end
    lvl_q <= lvl_d;
    idx_q <= idx_d;
    if (cmd_i.cur_node) begin
      cur_q <= VW'(node_q);
    end else if (cmd_i.cur_rdata) begin
      cur_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      res_q     <= res_d;
      res_isq_q <= (req_type_q == kab_pkg::REQ_QUERY);
    end
    if (cmd_i.out_load) begin
      anc_q <= res_q;
      isq_q <= res_isq_q;
    end
  end

  assign lvl_sel = cmd_i.lvl_plus ? lvl_q + 1'b1 : lvl_q;

  always_comb begin
    case (cmd_i.addr_sel)
      kab_pkg::ADDR_CUR:   node_sel = NW'(cur_q);
      kab_pkg::ADDR_NODE:  node_sel = NW'(node_q);
      kab_pkg::ADDR_RDATA: node_sel = NW'(rdata_q);
      default:             node_sel = idx_q;
    endcase
  end

  assign addr = AW'(lvl_sel) * AW'(MAX_NODES) + AW'(node_sel);

  assign parent_val = (!parent_q[VW-1] && (CW'(parent_q[VW-2:0]) < max_ext))
                    ? parent_q : kab_pkg::VAL_NONE;

  always_comb begin
    case (cmd_i.wdata_sel)
      kab_pkg::WD_PARENT: wdata = parent_val;
      kab_pkg::WD_RDATA:  wdata = rdata_q;
      default:            wdata = kab_pkg::VAL_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr];
    end
  end

  assign steps_shift = steps_q >> lvl_q;

  assign status_o.req_type      = req_type_q;
  assign status_o.count_zero    = (cnt == '0);
  assign status_o.count_le1     = (cnt <= CW'(1));
  assign status_o.query_bad     = (CW'(node_q) >= cnt) || ((steps_q >> LIFT_LEVELS) != '0);
  assign status_o.node_in_range = (CW'(node_q) < max_ext);
  assign status_o.lvl_zero      = (lvl_q == '0);
  assign status_o.lvl_top       = (lvl_q == LW'(LIFT_LEVELS - 1));
  assign status_o.lvl_next_top  = (lvl_q == LW'(LIFT_LEVELS - 2));
  assign status_o.idx_last      = ((CW'(idx_q) + CW'(1)) >= cnt);
  assign status_o.step_bit      = steps_shift[0];
  assign status_o.rd_is_node    = !rdata_q[VW-1] && (CW'(rdata_q) < max_ext);

  assign ancestor_o = anc_q;
  assign is_query_o = isq_q;

endmodule

[src/kth_ancestor_binary_lifting.sv]
// Channel  Dir  Fields                              Transfer
// req      in   req_type, node, parent, steps       valid && ready
// rsp      out  ancestor, is_query                  valid && ready
// cfg      in   node_count                          valid && ready, always ready
// A load, an unknown request or a rejected query goes from dispatch straight to its result,
// and the next request can be taken in the same cycle that its result word shows.
// A query walks the levels from the top, reading the table once for each set bit of steps.
// A build marks node 0 as having no ancestor at every level, then fills each higher level
// from the one below it for the other nodes; the next request is taken while a result word waits in rsp.
// Reset clears only control state and sets node_count to 1; the table needs no clearing pass.
module kth_ancestor_binary_lifting #(
  parameter int unsigned MAX_NODES   = 65536,
  parameter int unsigned LIFT_LEVELS = 17
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kab_req_if.sink   req,
  kab_rsp_if.source rsp,
  kab_cfg_if.sink   cfg
);

  kab_pkg::cmd_t    cmd;
  kab_pkg::status_t status;

  assign cfg.ready = 1'b1;

  kab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_ready_i (rsp.ready),
    .rsp_valid_o (rsp.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kab_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (req.req_type),
    .node_i      (req.node),
    .parent_i    (req.parent),
    .steps_i     (req.steps),
    .cfg_we_i    (cfg.valid),
    .cfg_count_i (cfg.node_count),
    .cmd_i       (cmd),
    .status_o    (status),
    .ancestor_o  (rsp.ancestor),
    .is_query_o  (rsp.is_query)
  );

endmodule

[src/kab_checker.sv]
`include "kth_ancestor_binary_lifting_defines.svh"

module kab_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic [kab_pkg::VAL_W-1:0]        rsp_ancestor_i,
  input logic                             rsp_is_query_i
);

  `KAB_ASSERT_NEXT(a_busy_after_accept, req_valid_i && req_ready_i, !req_ready_i, "ready right after accept")
  `KAB_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result word dropped")
  `KAB_ASSERT_IMPLY(a_ack_zero, rsp_valid_i && !rsp_is_query_i, rsp_ancestor_i == '0, "ack not zero")
  `KAB_ASSERT_IMPLY(a_anc_form, rsp_valid_i && rsp_is_query_i, !rsp_ancestor_i[kab_pkg::VAL_W-1] || rsp_ancestor_i == kab_pkg::VAL_NONE, "bad ancestor")

endmodule

bind kth_ancestor_binary_lifting kab_checker u_kab_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req.valid),
  .req_ready_i    (req.ready),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_ancestor_i (rsp.ancestor),
  .rsp_is_query_i (rsp.is_query)
);
